/* src/lwh_pkg.sv */
// shared constants, codes and controller/datapath interface types
package lwh_pkg;

  localparam int MAX_WALK_DEF   = 7;
  localparam int COUNT_BITS_DEF = 20;

  localparam int WL_W    = 3;
  localparam int DIR_W   = 3;
  localparam int LIMIT_W = 8;
  localparam int FRAC_W  = 17;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [WL_W-1:0] WALK_LENGTH_RST = 3'd7;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [DIR_W-1:0] DIR_X_NEG = 3'd0;
  localparam logic [DIR_W-1:0] DIR_X_POS = 3'd1;
  localparam logic [DIR_W-1:0] DIR_Y_NEG = 3'd2;
  localparam logic [DIR_W-1:0] DIR_Y_POS = 3'd3;
  localparam logic [DIR_W-1:0] DIR_Z_NEG = 3'd4;
  localparam logic [DIR_W-1:0] DIR_Z_POS = 3'd5;

  localparam logic REG_WALK_LENGTH = 1'b0;

  typedef struct packed {
    logic clr_wr;
    logic step_take;
    logic query_take;
    logic rec_addr;
    logic rec_wr;
    logic scan_rd;
    logic div_load;
    logic div_step;
    logic load_out;
  } lwh_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rec_due;
    logic scan_last;
    logic div_last;
    logic out_free;
  } lwh_status_t;

endpackage

/* src/lwh_ram.sv */
// generic simple dual-port ram with registered read
module lwh_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 3375
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/lwh_ctrl.sv */
// controller state machine: clearing pass, step recording, scan, divide, result
module lwh_ctrl import lwh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        cmd,
  output logic        in_ready,
  input  lwh_status_t status,
  output lwh_cmd_t    ctl
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_REC_ADDR = 4'd2;
  localparam logic [3:0] S_REC_WR   = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_DRAIN    = 4'd5;
  localparam logic [3:0] S_DIV_LD   = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_STEP) begin
            ctl.step_take = 1'b1;
            if (status.rec_due) begin
              state_next = S_REC_ADDR;
            end
          end else begin
            ctl.query_take = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_REC_ADDR: begin
        ctl.rec_addr = 1'b1;
        state_next   = S_REC_WR;
      end
      S_REC_WR: begin
        ctl.rec_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        ctl.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DIV_LD;
      end
      S_DIV_LD: begin
        ctl.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* src/lwh_datapath.sv */
// datapath: particle position, histogram ram, scan accumulators, divider, result register
module lwh_datapath import lwh_pkg::*; #(
  parameter int MAX_WALK   = MAX_WALK_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lwh_cmd_t              ctl,
  output lwh_status_t           status,
  input  logic [WL_W-1:0]       walk_length,
  input  logic [DIR_W-1:0]      direction,
  input  logic [LIMIT_W-1:0]    radius_sq_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_BITS-1:0] inside_count,
  output logic [COUNT_BITS-1:0] total_count,
  output logic [FRAC_W-1:0]     fraction_q16,
  output logic                  empty_res
);

  localparam int DIM    = 2 * MAX_WALK + 1;
  localparam int NBINS  = DIM * DIM * DIM;
  localparam int ADDR_W = $clog2(NBINS);
  localparam int CRD_W  = $clog2(DIM);
  localparam int SQ_W   = $clog2(3 * MAX_WALK * MAX_WALK + 1);
  localparam int CMP_W  = (SQ_W > LIMIT_W) ? SQ_W : LIMIT_W;
  localparam int CNT_W  = $clog2(FRAC_W);

  localparam logic [CRD_W-1:0]      CRD_TOP  = CRD_W'(DIM - 1);
  localparam logic [CRD_W-1:0]      CRD_MID  = CRD_W'(MAX_WALK);
  localparam logic [ADDR_W-1:0]     ADDR_TOP = ADDR_W'(NBINS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

  // position, offset so that the origin sits at MAX_WALK
  logic [CRD_W-1:0] pos_x;
  logic [CRD_W-1:0] pos_y;
  logic [CRD_W-1:0] pos_z;
  logic [WL_W-1:0]  steps_taken;
  logic [WL_W-1:0]  len;
  logic [ADDR_W-1:0] rec_idx;
  logic [ADDR_W-1:0] rec_addr_q;

  logic [ADDR_W-1:0] clr_addr;

  logic [LIMIT_W-1:0] limit;
  logic [ADDR_W-1:0]  scan_addr;
  logic [CRD_W-1:0]   scan_x;
  logic [CRD_W-1:0]   scan_y;
  logic [CRD_W-1:0]   scan_z;
  logic               scan_vld;
  logic               in_flag;
  logic [CRD_W-1:0]          ax;
  logic [CRD_W-1:0]          ay;
  logic [CRD_W-1:0]          az;
  logic [2*CRD_W-1:0]        sqx;
  logic [2*CRD_W-1:0]        sqy;
  logic [2*CRD_W-1:0]        sqz;
  logic [SQ_W-1:0]           d2;

  logic [COUNT_BITS-1:0] inside_acc;
  logic [COUNT_BITS-1:0] total_acc;
  logic [COUNT_BITS:0]   inside_sum;
  logic [COUNT_BITS:0]   total_sum;

  logic [COUNT_BITS:0] rem;
  logic [COUNT_BITS:0] rem_sh;
  logic                rem_ge;
  logic [FRAC_W-1:0]   quo;
  logic [CNT_W-1:0]    div_cnt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // steps per particle after limiting
  always_comb begin
    if (walk_length == '0) begin
      len = WL_W'(1);
    end else if (int'(walk_length) > MAX_WALK) begin
      len = WL_W'(MAX_WALK);
    end else begin
      len = walk_length;
    end
  end

  assign rec_idx = ADDR_W'(pos_x) + ADDR_W'(pos_y) * ADDR_W'(DIM)
                 + ADDR_W'(pos_z) * ADDR_W'(DIM * DIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= CRD_MID;
      pos_y       <= CRD_MID;
      pos_z       <= CRD_MID;
      steps_taken <= '0;
    end else if (ctl.step_take) begin
      case (direction)
        DIR_X_NEG: if (pos_x != '0) pos_x <= pos_x - 1'b1;
        DIR_X_POS: if (pos_x != CRD_TOP) pos_x <= pos_x + 1'b1;
        DIR_Y_NEG: if (pos_y != '0) pos_y <= pos_y - 1'b1;
        DIR_Y_POS: if (pos_y != CRD_TOP) pos_y <= pos_y + 1'b1;
        DIR_Z_NEG: if (pos_z != '0) pos_z <= pos_z - 1'b1;
        DIR_Z_POS: if (pos_z != CRD_TOP) pos_z <= pos_z + 1'b1;
        default: begin
        end
      endcase
      steps_taken <= status.rec_due ? '0 : steps_taken + 1'b1;
    end else if (ctl.rec_addr) begin
      pos_x <= CRD_MID;
      pos_y <= CRD_MID;
      pos_z <= CRD_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rec_addr) begin
      rec_addr_q <= rec_idx;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // scan counters, x fastest to follow the linear bin address
  always_ff @(posedge clk) begin
    if (ctl.query_take) begin
      limit     <= radius_sq_limit;
      scan_addr <= '0;
      scan_x    <= '0;
      scan_y    <= '0;
      scan_z    <= '0;
    end else if (ctl.scan_rd) begin
      scan_addr <= scan_addr + 1'b1;
      if (scan_x == CRD_TOP) begin
        scan_x <= '0;
        if (scan_y == CRD_TOP) begin
          scan_y <= '0;
          scan_z <= scan_z + 1'b1;
        end else begin
          scan_y <= scan_y + 1'b1;
        end
      end else begin
        scan_x <= scan_x + 1'b1;
      end
    end
  end

  // distance of each scan coordinate from the origin
  assign ax  = (scan_x >= CRD_MID) ? scan_x - CRD_MID : CRD_MID - scan_x;
  assign ay  = (scan_y >= CRD_MID) ? scan_y - CRD_MID : CRD_MID - scan_y;
  assign az  = (scan_z >= CRD_MID) ? scan_z - CRD_MID : CRD_MID - scan_z;
  assign sqx = {{CRD_W{1'b0}}, ax} * {{CRD_W{1'b0}}, ax};
  assign sqy = {{CRD_W{1'b0}}, ay} * {{CRD_W{1'b0}}, ay};
  assign sqz = {{CRD_W{1'b0}}, az} * {{CRD_W{1'b0}}, az};
  assign d2  = SQ_W'(sqx) + SQ_W'(sqy) + SQ_W'(sqz);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= ctl.scan_rd;
    end
    in_flag <= (CMP_W'(d2) <= CMP_W'(limit));
  end

  // saturating accumulation of each registered bin read
  assign inside_sum = {1'b0, inside_acc} + {1'b0, ram_rdata};
  assign total_sum  = {1'b0, total_acc} + {1'b0, ram_rdata};

  always_ff @(posedge clk) begin
    if (rst || ctl.query_take) begin
      inside_acc <= '0;
      total_acc  <= '0;
    end else if (scan_vld) begin
      total_acc <= total_sum[COUNT_BITS] ? CNT_MAX : total_sum[COUNT_BITS-1:0];
      if (in_flag) begin
        inside_acc <= inside_sum[COUNT_BITS] ? CNT_MAX : inside_sum[COUNT_BITS-1:0];
      end
    end
  end

  // restoring divider, one quotient bit per cycle, inside never exceeds total
  assign rem_sh = (div_cnt == '0) ? rem : {rem[COUNT_BITS-1:0], 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, total_acc});

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem     <= {1'b0, inside_acc};
      quo     <= '0;
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      rem     <= rem_ge ? rem_sh - {1'b0, total_acc} : rem_sh;
      quo     <= {quo[FRAC_W-2:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      inside_count <= inside_acc;
      total_count  <= total_acc;
      fraction_q16 <= (total_acc == '0) ? '0 : quo;
      empty_res    <= (total_acc == '0);
    end
  end

  // histogram memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rec_addr_q;
    ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
    if (ctl.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (ctl.rec_wr) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = ctl.rec_addr ? rec_idx : scan_addr;

  lwh_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NBINS)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    status.clr_last  = (clr_addr == ADDR_TOP);
    status.rec_due   = ({1'b0, steps_taken} + 1'b1) >= {1'b0, len};
    status.scan_last = (scan_addr == ADDR_TOP);
    status.div_last  = (div_cnt == CNT_W'(FRAC_W - 1));
    status.out_free  = !out_valid || out_ready;
  end

  a_inside_le_total: assert property (@(posedge clk) disable iff (rst)
    inside_acc <= total_acc)
    else $error("inside sum above total sum");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (pos_x <= CRD_TOP) && (pos_y <= CRD_TOP) && (pos_z <= CRD_TOP))
    else $error("particle outside lattice");

  a_rec_origin: assert property (@(posedge clk) disable iff (rst)
    ctl.rec_addr |=> (pos_x == CRD_MID) && (pos_y == CRD_MID) && (pos_z == CRD_MID)
                     && (steps_taken == '0))
    else $error("particle not back at origin after recording");

  a_load_out: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> out_valid)
    else $error("result not presented after load");

endmodule

/* src/lattice_walk_endpoint_histogram_core.sv */
// top level: configuration register, controller and datapath
//
// A step request is taken while the block is idle; when it ends a walk, the end
// point is then counted by a read-modify-write of the histogram memory before
// the next request is accepted. The result of a query request is presented
// after one histogram read per bin and then a restoring divide for the Q1.16
// fraction. One request is in work at a time; a finished result waits in the
// output register while step requests keep being accepted. After reset the
// block runs a clearing pass over every bin of the histogram before it accepts
// the first request; configuration writes are taken throughout.
module lattice_walk_endpoint_histogram_core import lwh_pkg::*; #(
  parameter int MAX_WALK   = MAX_WALK_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [DIR_W-1:0]      direction,
  input  logic [LIMIT_W-1:0]    radius_sq_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_BITS-1:0] inside_count,
  output logic [COUNT_BITS-1:0] total_count,
  output logic [FRAC_W-1:0]     fraction_q16,
  output logic                  empty_res
);

  logic [WL_W-1:0] walk_length;
  logic            reg_sel;
  lwh_cmd_t        ctl;
  lwh_status_t     status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_WALK_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_length <= WALK_LENGTH_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      walk_length <= pwdata[WL_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(PDATA_W-WL_W){1'b0}}, walk_length} : '0;

  lwh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .cmd     (cmd),
    .in_ready(in_ready),
    .status  (status),
    .ctl     (ctl)
  );

  lwh_datapath #(
    .MAX_WALK  (MAX_WALK),
    .COUNT_BITS(COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .status         (status),
    .walk_length    (walk_length),
    .direction      (direction),
    .radius_sq_limit(radius_sq_limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .inside_count   (inside_count),
    .total_count    (total_count),
    .fraction_q16   (fraction_q16),
    .empty_res      (empty_res)
  );

endmodule

/* dv/lattice_walk_endpoint_histogram_core_test.sv */
// self-checking testbench for the lattice walk endpoint histogram core
`timescale 1ns / 100ps

module lattice_walk_endpoint_histogram_core_test import lwh_pkg::*;;

  localparam int DIM          = 2 * MAX_WALK_DEF + 1;
  localparam int NUM_BINS     = DIM * DIM * DIM;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 32;
  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int PHASE_ITEMS  = 50;
  localparam int QUERY_PCT    = 12;

  localparam logic [DIR_W-1:0] DIR_STAY_6 = 3'd6;
  localparam logic [DIR_W-1:0] DIR_STAY_7 = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                 cmd;
    logic [DIR_W-1:0]     direction;
    logic [LIMIT_W-1:0]   radius_sq_limit;
  } walk_req_t;

  typedef struct packed {
    logic [COUNT_BITS_DEF-1:0] inner;
    logic [COUNT_BITS_DEF-1:0] total;
    logic [FRAC_W-1:0]         frac;
    logic                      empty;
  } density_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = CMD_STEP;
  logic [DIR_W-1:0] direction = '0;
  logic [LIMIT_W-1:0] radius_sq_limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COUNT_BITS_DEF-1:0] inside_count;
  logic [COUNT_BITS_DEF-1:0] total_count;
  logic [FRAC_W-1:0] fraction_q16;
  logic empty_res;

  walk_req_t pending_walk_reqs[$];
  density_t  expected_densities[$];
  int unsigned issued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic req_taken = 1'b0;

  // predictor state
  logic [WL_W-1:0] walk_len = WALK_LENGTH_RST;
  int pos_x = 0;
  int pos_y = 0;
  int pos_z = 0;
  int steps_done = 0;
  logic [COUNT_BITS_DEF-1:0] endpoint_hist[NUM_BINS];

  lattice_walk_endpoint_histogram_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .direction(direction),
    .radius_sq_limit(radius_sq_limit),
    .out_valid(out_valid), .out_ready(out_ready), .inside_count(inside_count),
    .total_count(total_count), .fraction_q16(fraction_q16), .empty_res(empty_res)
  );

  always #6 clk = ~clk;

  function automatic int clamp_coord(int v);
    if (v > MAX_WALK_DEF) return MAX_WALK_DEF;
    if (v < -MAX_WALK_DEF) return -MAX_WALK_DEF;
    return v;
  endfunction

  function automatic int bin_of(int x, int y, int z);
    return (x + MAX_WALK_DEF) + (y + MAX_WALK_DEF) * DIM + (z + MAX_WALK_DEF) * DIM * DIM;
  endfunction

  function automatic void apply_walk_request(walk_req_t r);
    int len;
    int k;
    int d2;
    longint unsigned in_sum;
    longint unsigned all_sum;
    longint unsigned frac;
    density_t res;
    if (r.cmd == CMD_STEP) begin
      len = (walk_len == 0) ? 1 : int'(walk_len);
      if (len > MAX_WALK_DEF) len = MAX_WALK_DEF;
      case (r.direction)
        DIR_X_NEG: pos_x = clamp_coord(pos_x - 1);
        DIR_X_POS: pos_x = clamp_coord(pos_x + 1);
        DIR_Y_NEG: pos_y = clamp_coord(pos_y - 1);
        DIR_Y_POS: pos_y = clamp_coord(pos_y + 1);
        DIR_Z_NEG: pos_z = clamp_coord(pos_z - 1);
        DIR_Z_POS: pos_z = clamp_coord(pos_z + 1);
        default: ;
      endcase
      steps_done++;
      if (steps_done >= len) begin
        k = bin_of(pos_x, pos_y, pos_z);
        if (endpoint_hist[k] != COUNT_MAX[COUNT_BITS_DEF-1:0])
          endpoint_hist[k] = endpoint_hist[k] + 1'b1;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        steps_done = 0;
      end
    end else begin
      in_sum = 0;
      all_sum = 0;
      for (int z = -MAX_WALK_DEF; z <= MAX_WALK_DEF; z++)
        for (int y = -MAX_WALK_DEF; y <= MAX_WALK_DEF; y++)
          for (int x = -MAX_WALK_DEF; x <= MAX_WALK_DEF; x++) begin
            d2 = x * x + y * y + z * z;
            k = bin_of(x, y, z);
            if (d2 <= int'(r.radius_sq_limit)) begin
              in_sum = in_sum + endpoint_hist[k];
              if (in_sum > COUNT_MAX) in_sum = COUNT_MAX;
            end
            all_sum = all_sum + endpoint_hist[k];
            if (all_sum > COUNT_MAX) all_sum = COUNT_MAX;
          end
      frac = (all_sum != 0) ? (in_sum << 16) / all_sum : 0;
      res.inner  = in_sum[COUNT_BITS_DEF-1:0];
      res.total  = all_sum[COUNT_BITS_DEF-1:0];
      res.frac   = frac[FRAC_W-1:0];
      res.empty  = (all_sum == 0);
      expected_densities.push_back(res);
    end
  endfunction

  function automatic void queue_req(logic c, logic [DIR_W-1:0] d, logic [LIMIT_W-1:0] lim);
    walk_req_t r;
    r.cmd = c;
    r.direction = d;
    r.radius_sq_limit = lim;
    pending_walk_reqs.push_back(r);
    issued_cnt++;
  endfunction

  task automatic wait_until_idle();
    while (accepted_cnt != issued_cnt || expected_densities.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_walk_length(logic [WL_W-1:0] wl);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_WALK_LENGTH);
    pwdata  <= ($urandom() & ~32'h7) | PDATA_W'(wl);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    walk_len = wl;
  endtask

  task automatic set_idle_mode(idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default:   begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  // request driver
  always @(negedge clk) begin : req_driver
    walk_req_t nxt;
    if (!in_valid || req_taken) begin
      if (pending_walk_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_walk_reqs.pop_front();
        in_valid        <= 1'b1;
        cmd             <= nxt.cmd;
        direction       <= nxt.direction;
        radius_sq_limit <= nxt.radius_sq_limit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // acceptance tracking and result checking
  always @(posedge clk) begin : result_checker
    walk_req_t got_req;
    density_t want;
    req_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      got_req.cmd = cmd;
      got_req.direction = direction;
      got_req.radius_sq_limit = radius_sq_limit;
      apply_walk_request(got_req);
      accepted_cnt++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_densities.size() == 0) begin
        $error("result with no query outstanding");
        err_cnt++;
      end else begin
        want = expected_densities.pop_front();
        if (inside_count !== want.inner) begin
          $error("inside_count expected %0d got %0d", want.inner, inside_count);
          err_cnt++;
        end
        if (total_count !== want.total) begin
          $error("total_count expected %0d got %0d", want.total, total_count);
          err_cnt++;
        end
        if (fraction_q16 !== want.frac) begin
          $error("fraction_q16 expected %0d got %0d", want.frac, fraction_q16);
          err_cnt++;
        end
        if (empty_res !== want.empty) begin
          $error("empty_res expected %0d got %0d", want.empty, empty_res);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [WL_W-1:0] phase_wl[8];
    logic [DIR_W-1:0] d;
    logic [LIMIT_W-1:0] lim;
    phase_wl = '{3'd1, 3'd7, 3'd3, 3'd0, 3'd5, 3'd2, 3'd6, 3'd4};
    foreach (endpoint_hist[i]) endpoint_hist[i] = '0;
    set_idle_mode(IDLE_NONE);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty histogram, then a full walk to the lattice edge
    queue_req(CMD_QUERY, DIR_X_NEG, 8'd0);
    repeat (7) queue_req(CMD_STEP, DIR_X_POS, 8'hff);
    queue_req(CMD_QUERY, DIR_Z_POS, 8'd255);
    queue_req(CMD_QUERY, DIR_STAY_7, 8'd48);
    queue_req(CMD_QUERY, DIR_STAY_6, 8'd49);
    queue_req(CMD_STEP, DIR_X_NEG, 8'd0);
    queue_req(CMD_STEP, DIR_Y_NEG, 8'd147);
    queue_req(CMD_STEP, DIR_Y_POS, 8'd0);
    queue_req(CMD_STEP, DIR_Z_NEG, 8'd0);
    queue_req(CMD_STEP, DIR_Z_POS, 8'd0);
    queue_req(CMD_STEP, DIR_STAY_6, 8'd0);
    queue_req(CMD_STEP, DIR_STAY_7, 8'd0);
    queue_req(CMD_QUERY, DIR_X_NEG, 8'd0);
    repeat (3) queue_req(CMD_STEP, DIR_Z_NEG, 8'd0);
    wait_until_idle();

    // shorter walk length mid-walk: recorded on the next step
    write_walk_length(3'd2);
    queue_req(CMD_STEP, DIR_Z_POS, 8'd0);
    queue_req(CMD_QUERY, DIR_X_NEG, 8'd4);
    wait_until_idle();

    // zero walk length behaves as one
    write_walk_length(3'd0);
    queue_req(CMD_STEP, DIR_Y_POS, 8'd0);
    queue_req(CMD_STEP, DIR_STAY_6, 8'd0);
    queue_req(CMD_QUERY, DIR_X_NEG, 8'd147);

    for (int p = 0; p < 8; p++) begin
      wait_until_idle();
      write_walk_length(phase_wl[p]);
      set_idle_mode(idle_mode_t'(p % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        d = DIR_W'($urandom_range(7));
        lim = ($urandom_range(3) == 0) ? LIMIT_W'($urandom_range(255))
                                       : LIMIT_W'($urandom_range(147));
        if ($urandom_range(99) < QUERY_PCT) queue_req(CMD_QUERY, d, lim);
        else queue_req(CMD_STEP, d, lim);
      end
    end

    wait_until_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* lattice_walk_endpoint_histogram_core.f */
src/lwh_pkg.sv
src/lwh_ram.sv
src/lwh_ctrl.sv
src/lwh_datapath.sv
src/lattice_walk_endpoint_histogram_core.sv
dv/lattice_walk_endpoint_histogram_core_test.sv
